>>> rtl/core/vcs_pkg.sv
// vcs_pkg: shared widths, queue entry type and status struct for the cosine similarity unit
// depends on: nothing
package vcs_pkg;

   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int SQ_W       = PROD_W - 1;
   localparam int DOT_W      = 44;
   localparam int NORM_W     = 43;
   localparam int SIM_W      = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int DIGIT_W    = 16;
   localparam int MP_W       = 3 * DIGIT_W;
   localparam int MUL_W      = 88;
   localparam int D2_W       = 2 * DOT_W - 1;
   localparam int PP_W       = 2 * NORM_W;
   localparam int QUO_W      = 32;
   localparam int ROOT_W     = QUO_W / 2;
   localparam int SREM_W     = ROOT_W + 2;

   // sums of one finished vector pair
   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
   } vcs_sums_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic not_empty;
      logic near_full;
   } vcs_fifo_stat_type;

endpackage

>>> rtl/core/vcs_front.sv
// vcs_front: product stage and saturating accumulators, pushes sums on the last pair
// depends on: vcs_pkg
module vcs_front import vcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_elem_a,
   input  logic signed [ELEM_W-1:0] req_elem_b,
   input  logic                     req_last_elem,
   input  vcs_fifo_stat_type        fifo_stat,
   output logic                     push,
   output vcs_sums_type             sums
);

   logic                     accept;
   logic signed [PROD_W-1:0] ab_in, aa_in, bb_in;
   logic                     p_valid_ff, p_last_ff;
   logic signed [PROD_W-1:0] p_ab_ff;
   logic [SQ_W-1:0]          p_aa_ff, p_bb_ff;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [NORM_W-1:0]        na_ff, nb_ff, na_in, nb_in;
   logic signed [DOT_W:0]    dot_sum;
   logic [NORM_W:0]          na_sum, nb_sum;
   logic                     push_ff;
   vcs_sums_type             sums_ff;

   assign req_stall = fifo_stat.near_full;
   assign accept    = req_valid && !req_stall;

   // element products
   always_comb begin
      ab_in = req_elem_a * req_elem_b;
      aa_in = req_elem_a * req_elem_a;
      bb_in = req_elem_b * req_elem_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
      if (accept) begin
         p_last_ff <= req_last_elem;
         p_ab_ff   <= ab_in;
         p_aa_ff   <= aa_in[SQ_W-1:0];
         p_bb_ff   <= bb_in[SQ_W-1:0];
      end
   end

   // saturating sums
   always_comb begin
      dot_sum = {dot_ff[DOT_W-1], dot_ff} + (DOT_W+1)'(p_ab_ff);
      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
         dot_in = {dot_sum[DOT_W], {(DOT_W-1){~dot_sum[DOT_W]}}};
      end else begin
         dot_in = dot_sum[DOT_W-1:0];
      end
      na_sum = {1'b0, na_ff} + (NORM_W+1)'(p_aa_ff);
      nb_sum = {1'b0, nb_ff} + (NORM_W+1)'(p_bb_ff);
      na_in  = na_sum[NORM_W] ? {NORM_W{1'b1}} : na_sum[NORM_W-1:0];
      nb_in  = nb_sum[NORM_W] ? {NORM_W{1'b1}} : nb_sum[NORM_W-1:0];
   end

   // accumulators, cleared after each last pair
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         na_ff   <= '0;
         nb_ff   <= '0;
         push_ff <= 1'b0;
      end else begin
         push_ff <= p_valid_ff && p_last_ff;
         if (p_valid_ff) begin
            if (p_last_ff) begin
               dot_ff <= '0;
               na_ff  <= '0;
               nb_ff  <= '0;
            end else begin
               dot_ff <= dot_in;
               na_ff  <= na_in;
               nb_ff  <= nb_in;
            end
         end
      end
      if (p_valid_ff && p_last_ff) begin
         sums_ff.dot    <= dot_in;
         sums_ff.norm_a <= na_in;
         sums_ff.norm_b <= nb_in;
      end
   end

   assign push = push_ff;
   assign sums = sums_ff;

endmodule

>>> rtl/core/vcs_fifo.sv
// vcs_fifo: short queue of finished sums between front and back
// depends on: vcs_pkg
module vcs_fifo import vcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vcs_sums_type      push_data,
   input  logic              pop,
   output vcs_sums_type      head,
   output vcs_fifo_stat_type stat
);

   vcs_sums_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.near_full = (count_ff >= (FIFO_AW+1)'(FIFO_DEPTH - 2));

endmodule

>>> rtl/core/vcs_back.sv
// vcs_back: sequencer for the squared dot, norm product, division and root that forms the similarity
// depends on: vcs_pkg
module vcs_back import vcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  vcs_fifo_stat_type       fifo_stat,
   input  vcs_sums_type            head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SIM_W-1:0] rsp_similarity,
   output logic                    rsp_degenerate
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_CMP, S_DIV, S_SQRT, S_FIN
   } state_type;

   state_type               state_ff;
   logic [DOT_W-1:0]        mag;
   logic [DOT_W-1:0]        mc_ff;
   logic [MP_W-1:0]         mp_ff;
   logic [MUL_W-1:0]        prod_ff, prod_in;
   logic                    phase_ff;
   logic [4:0]              cnt_ff;
   logic [NORM_W-1:0]       na_ff, nb_ff;
   logic [D2_W-1:0]         d2_ff;
   logic [PP_W-1:0]         pp_ff;
   logic [PP_W-1:0]         rem_ff;
   logic [PP_W:0]           rem2;
   logic                    div_ge;
   logic [QUO_W-1:0]        quo_ff;
   logic                    ovf_ff, neg_ff, degen_ff;
   logic [ROOT_W-1:0]       root_ff;
   logic [SREM_W-1:0]       srem_ff;
   logic [SREM_W+1:0]       s_sh, s_trial;
   logic                    s_ge;
   logic [ROOT_W-1:0]       k_mag;
   logic signed [SIM_W-1:0] sim_in;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_deg_ff;
   logic signed [SIM_W-1:0] rsp_sim_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && fifo_stat.not_empty;

   // datapath terms for the current step
   always_comb begin
      mag     = head.dot[DOT_W-1] ? DOT_W'(-head.dot) : DOT_W'(head.dot);
      prod_in = {prod_ff[MUL_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                + MUL_W'(mc_ff * mp_ff[MP_W-1 -: DIGIT_W]);
      rem2    = {rem_ff, 1'b0};
      div_ge  = rem2 >= {1'b0, pp_ff};
      s_sh    = {srem_ff, quo_ff[QUO_W-1 -: 2]};
      s_trial = {2'b00, root_ff, 2'b01};
      s_ge    = s_sh >= s_trial;
      // magnitude tops out at one, which is 32768 in Q1.15
      if (ovf_ff) begin
         k_mag = ROOT_W'(1) << (ROOT_W - 1);
      end else begin
         k_mag = ROOT_W'(({1'b0, root_ff} + (ROOT_W+1)'(1)) >> 1);
      end
      if (degen_ff) begin
         sim_in = '0;
      end else if (neg_ff) begin
         sim_in = SIM_W'(-k_mag);
      end else if (k_mag[ROOT_W-1]) begin
         sim_in = {1'b0, {(SIM_W-1){1'b1}}};
      end else begin
         sim_in = SIM_W'(k_mag);
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (fifo_stat.not_empty) begin
                  mc_ff    <= mag;
                  mp_ff    <= MP_W'(mag);
                  prod_ff  <= '0;
                  phase_ff <= 1'b0;
                  cnt_ff   <= '0;
                  na_ff    <= head.norm_a;
                  nb_ff    <= head.norm_b;
                  neg_ff   <= head.dot[DOT_W-1];
                  ovf_ff   <= 1'b0;
                  degen_ff <= (head.norm_a == '0) || (head.norm_b == '0);
                  if ((head.norm_a == '0) || (head.norm_b == '0)) begin
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               if (cnt_ff == 5'd2) begin
                  cnt_ff <= '0;
                  if (!phase_ff) begin
                     d2_ff    <= prod_in[D2_W-1:0];
                     mc_ff    <= DOT_W'(na_ff);
                     mp_ff    <= MP_W'(nb_ff);
                     prod_ff  <= '0;
                     phase_ff <= 1'b1;
                  end else begin
                     pp_ff    <= prod_in[PP_W-1:0];
                     state_ff <= S_CMP;
                  end
               end else begin
                  prod_ff <= prod_in;
                  mp_ff   <= mp_ff << DIGIT_W;
                  cnt_ff  <= cnt_ff + 5'd1;
               end
            end
            S_CMP: begin
               rem_ff <= d2_ff[PP_W-1:0];
               quo_ff <= '0;
               cnt_ff <= '0;
               if (d2_ff >= {1'b0, pp_ff}) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= div_ge ? PP_W'(rem2 - {1'b0, pp_ff}) : rem2[PP_W-1:0];
               quo_ff <= {quo_ff[QUO_W-2:0], div_ge};
               if (cnt_ff == 5'(QUO_W - 1)) begin
                  cnt_ff   <= '0;
                  root_ff  <= '0;
                  srem_ff  <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_SQRT: begin
               srem_ff <= s_ge ? SREM_W'(s_sh - s_trial) : s_sh[SREM_W-1:0];
               root_ff <= {root_ff[ROOT_W-2:0], s_ge};
               quo_ff  <= quo_ff << 2;
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ROOT_W - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sim_ff   <= sim_in;
                  rsp_deg_ff   <= degen_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_degenerate = rsp_deg_ff;

endmodule

>>> rtl/core/vector_cosine_similarity_unit.sv
// vector_cosine_similarity_unit: top level, streaming cosine similarity of paired vectors
// depends on: vcs_pkg, vcs_front, vcs_fifo, vcs_back
//
//   channel | direction | ports                                        | transfer
//   req     | in        | req_elem_a, req_elem_b, req_last_elem        | valid && !stall
//   rsp     | out       | rsp_similarity, rsp_degenerate               | valid && !stall
//
// one element pair is taken per cycle unless req_stall is high; the result can transfer
// after the last pair once the back has run 6 multiply, 32 divide and 16 root steps;
// a zero-norm vector goes straight to the result, a full-scale ratio skips divide and root
// the back handles one vector at a time; the front runs ahead through a 4-entry
// queue of sums and stalls once two sums wait, leaving room for two still in flight
// synchronous active-high reset clears accumulators, queue and sequencer
// a stalled result holds in the output register while new pairs stream in until the queue fills
module vector_cosine_similarity_unit import vcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_elem_a,
   input  logic signed [ELEM_W-1:0] req_elem_b,
   input  logic                     req_last_elem,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SIM_W-1:0]  rsp_similarity,
   output logic                     rsp_degenerate
);

   vcs_fifo_stat_type fifo_stat;
   vcs_sums_type      push_data, head;
   logic              push, pop;

   // accumulation front
   vcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_elem_a    (req_elem_a),
      .req_elem_b    (req_elem_b),
      .req_last_elem (req_last_elem),
      .fifo_stat     (fifo_stat),
      .push          (push),
      .sums          (push_data)
   );

   // sums queue
   vcs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   // divide and root back end
   vcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_stat      (fifo_stat),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_similarity (rsp_similarity),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

>>> rtl/core/vcs_checker.sv
// vcs_checker: port-level assertions for the cosine similarity unit, bound to the top
// depends on: vcs_pkg, vector_cosine_similarity_unit
module vcs_checker import vcs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [SIM_W-1:0]  rsp_similarity,
   input logic                     rsp_degenerate
);

   // degenerate results carry zero similarity
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_similarity == '0)
      else $error("degenerate result with nonzero similarity");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty queue takes pairs right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_similarity)
         && $stable(rsp_degenerate))
      else $error("stalled result changed");

endmodule

bind vector_cosine_similarity_unit vcs_checker u_vcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_similarity (rsp_similarity),
   .rsp_degenerate (rsp_degenerate)
);

>>> tb/testbench.sv
// testbench: checks the streaming cosine similarity unit against a built-in predictor
// depends on: vcs_pkg, vector_cosine_similarity_unit
`timescale 1ns / 100ps

// keeps the running sums and the queue of similarities still to come
class similarity_scoreboard;
   logic signed [43:0] dot_sum;
   logic [42:0]        norm_a_sum;
   logic [42:0]        norm_b_sum;
   logic signed [15:0] sim_q[$];
   logic               deg_q[$];
   int                 errors;

   function new();
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      errors = 0;
   endfunction

   function int pending();
      return sim_q.size();
   endfunction

   // rounded magnitude of 32768*|dot|/sqrt(na*nb), found by bisection
   function logic [16:0] rounded_mag(logic [43:0] mag, logic [42:0] na, logic [42:0] nb);
      logic [191:0] target;
      logic [191:0] lhs;
      logic [16:0]  lo;
      logic [16:0]  hi;
      logic [16:0]  mid;
      logic [35:0]  t;
      target = ({148'd0, mag} * {148'd0, mag}) << 32;
      lo = '0;
      hi = 17'd32768;
      while (lo < hi) begin
         mid = 17'((lo + hi + 1) / 2);
         t = 36'(2 * mid - 1);
         lhs = {156'd0, t} * {156'd0, t} * {149'd0, na} * {149'd0, nb};
         if (lhs <= target) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // accepted element pair
   function void note(logic signed [15:0] a, logic signed [15:0] b, logic last);
      logic signed [63:0] d;
      logic [63:0]        s;
      logic [43:0]        mag;
      logic [16:0]        k;
      d = 64'(dot_sum) + 64'(a) * 64'(b);
      if (d > 64'sd8796093022207) d = 64'sd8796093022207;
      if (d < -64'sd8796093022208) d = -64'sd8796093022208;
      dot_sum = d[43:0];
      s = 64'(norm_a_sum) + 64'(64'(a) * 64'(a));
      norm_a_sum = (s > 64'h7FFFFFFFFFF) ? 43'h7FFFFFFFFFF : s[42:0];
      s = 64'(norm_b_sum) + 64'(64'(b) * 64'(b));
      norm_b_sum = (s > 64'h7FFFFFFFFFF) ? 43'h7FFFFFFFFFF : s[42:0];
      if (!last) return;
      if (norm_a_sum == 0 || norm_b_sum == 0) begin
         sim_q = {sim_q, 16'sd0};
         deg_q = {deg_q, 1'b1};
      end else begin
         mag = dot_sum < 0 ? 44'(-dot_sum) : 44'(dot_sum);
         k = rounded_mag(mag, norm_a_sum, norm_b_sum);
         if (dot_sum < 0) sim_q = {sim_q, 16'(-k)};
         else sim_q = {sim_q, (k > 32767) ? 16'sd32767 : 16'(k)};
         deg_q = {deg_q, 1'b0};
      end
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
   endfunction

   // accepted result against the oldest expectation
   function void check(logic signed [15:0] sim, logic deg);
      logic signed [15:0] esim;
      logic               edeg;
      if (sim_q.size() == 0) begin
         $display("%0t: unexpected result similarity=%0d degenerate=%0b", $time, sim, deg);
         errors++;
         return;
      end
      esim = sim_q.pop_front();
      edeg = deg_q.pop_front();
      if (sim !== esim) begin
         $display("%0t: similarity expected %0d actual %0d", $time, esim, sim);
         errors++;
      end
      if (deg !== edeg) begin
         $display("%0t: degenerate expected %0b actual %0b", $time, edeg, deg);
         errors++;
      end
   endfunction
endclass

module testbench import vcs_pkg::*;;

   localparam int WATCHDOG_LIMIT = 5000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_elem_a = '0;
   logic signed [ELEM_W-1:0] req_elem_b = '0;
   logic                     req_last_elem = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [SIM_W-1:0]  rsp_similarity;
   logic                     rsp_degenerate;

   similarity_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int sent = 0;

   vector_cosine_similarity_unit u_top (.*);

   always #4 clock = ~clock;

   // receiver stall pattern
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // result transfers and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_similarity, rsp_degenerate);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("testbench NOT OK");
         $finish;
      end
   end

   // one pair transfer, with random idle cycles ahead of it
   task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elem_a <= a;
      req_elem_b <= b;
      req_last_elem <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(a, b, last);
      sent++;
   endtask

   function automatic logic signed [15:0] rand_elem();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(255)) - 16'sd128;
         2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($urandom) >>> $urandom_range(15);
      endcase
   endfunction

   // one random vector pair of mostly short length
   task automatic send_vector();
      int len;
      int kind;
      logic signed [15:0] a;
      logic signed [15:0] b;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      kind = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         a = rand_elem();
         b = rand_elem();
         if (kind == 0) b = a;
         else if (kind == 1) b = (a == 16'sh8000) ? 16'sh7FFF : -a;
         else if (kind == 2) a = '0;
         else if (kind == 3) b = '0;
         send_pair(a, b, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, single pairs, zero vectors, parallel and antiparallel
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sd0, 16'sd5, 1'b1);
      send_pair(16'sd5, 16'sd0, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd1, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b1);
      send_pair(16'sd1, 16'sd1, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b1);
      send_pair(16'sd3, 16'sd4, 1'b0);
      send_pair(-16'sd2, 16'sd7, 1'b0);
      send_pair(16'sh5555, 16'shAAAA, 1'b1);
      send_pair(16'shFFFF, 16'sd1, 1'b1);
      send_pair(16'sd100, 16'sd99, 1'b0);
      send_pair(16'sd100, 16'sd101, 1'b1);
      wait_drained();

      // random phases with varied idling on both sides
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 21 : 58) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 21 : 58) : 0;
         count = sent;
         while (sent - count < 350) begin
            send_vector();
         end
         wait_drained();
      end

      if (sb.errors == 0 && sb.pending() == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/vcs_pkg.sv
rtl/core/vcs_front.sv
rtl/core/vcs_fifo.sv
rtl/core/vcs_back.sv
rtl/core/vector_cosine_similarity_unit.sv
rtl/core/vcs_checker.sv
tb/testbench.sv
